@@ design/dsfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types, codes and lookup functions for the date string field parser.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  localparam int CHAR_W   = 8;
  localparam int ORDER_W  = 3;
  localparam int SHORT_W  = 7;
  localparam int YEAR_W   = 14;
  localparam int STATUS_W = 3;
  localparam int DCNT_W   = 3;
  localparam int FCNT_W   = 2;

  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [DCNT_W-1:0] DIGITS_KEPT  = 3'd4;
  localparam logic [DCNT_W-1:0] DIGITS_SAT   = 3'd7;
  localparam logic [DCNT_W-1:0] SHORT_DIGITS = 3'd2;
  localparam logic [DCNT_W-1:0] YEAR_DIGITS  = 3'd4;
  localparam logic [FCNT_W-1:0] FIELDS_FULL  = 2'd3;
  localparam logic [SHORT_W-1:0] MONTHS      = 7'd12;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_INCOMPLETE = 3'd1,
    STAT_SHORT_LONG = 3'd2,
    STAT_YEAR_LONG  = 3'd3,
    STAT_BAD_CHAR   = 3'd4,
    STAT_EXTRA      = 3'd5,
    STAT_BAD_MONTH  = 3'd6,
    STAT_BAD_DAY    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ROLE_DAY   = 2'd0,
    ROLE_MONTH = 2'd1,
    ROLE_YEAR  = 2'd2
  } role_t;

  typedef enum logic [ORDER_W-1:0] {
    ORDER_DMY = 3'd0,
    ORDER_MDY = 3'd1,
    ORDER_YMD = 3'd2,
    ORDER_YDM = 3'd3,
    ORDER_MYD = 3'd4,
    ORDER_DYM = 3'd5
  } order_t;

  typedef struct packed {
    logic [SHORT_W-1:0] day;
    logic [SHORT_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    status_t            status;
  } result_t;

  function automatic role_t role_of(input logic [ORDER_W-1:0] order,
                                    input logic [FCNT_W-1:0] idx);
    role_t r0;
    role_t r1;
    role_t r2;
    begin
      r0 = ROLE_DAY;
      r1 = ROLE_MONTH;
      r2 = ROLE_YEAR;
      unique case (order)
        ORDER_MDY: begin r0 = ROLE_MONTH; r1 = ROLE_DAY;   r2 = ROLE_YEAR;  end
        ORDER_YMD: begin r0 = ROLE_YEAR;  r1 = ROLE_MONTH; r2 = ROLE_DAY;   end
        ORDER_YDM: begin r0 = ROLE_YEAR;  r1 = ROLE_DAY;   r2 = ROLE_MONTH; end
        ORDER_MYD: begin r0 = ROLE_MONTH; r1 = ROLE_YEAR;  r2 = ROLE_DAY;   end
        ORDER_DYM: begin r0 = ROLE_DAY;   r1 = ROLE_YEAR;  r2 = ROLE_MONTH; end
        default:   begin r0 = ROLE_DAY;   r1 = ROLE_MONTH; r2 = ROLE_YEAR;  end
      endcase
      unique case (idx)
        2'd0:    role_of = r0;
        2'd1:    role_of = r1;
        default: role_of = r2;
      endcase
    end
  endfunction

  function automatic logic [SHORT_W-1:0] month_len(input logic [SHORT_W-1:0] month);
    unique case (month)
      7'd2:                      month_len = 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   month_len = 7'd30;
      default:                   month_len = 7'd31;
    endcase
  endfunction

endpackage

@@ design/dsfp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfp_in_if
// Character request channel: one string character and its last flag.
// ----------------------------------------------------------------------------
interface dsfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [dsfp_pkg::CHAR_W-1:0]   char_code;
  logic                          last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ design/dsfp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfp_out_if
// Result request channel: parsed day, month, year and status.
// ----------------------------------------------------------------------------
interface dsfp_out_if;
  logic                            valid;
  logic                            ready;
  logic [dsfp_pkg::SHORT_W-1:0]    day;
  logic [dsfp_pkg::SHORT_W-1:0]    month;
  logic [dsfp_pkg::YEAR_W-1:0]     year;
  logic [dsfp_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output day, output month, output year, output status,
                  input ready);
  modport sink   (input valid, input day, input month, input year, input status,
                  output ready);
endinterface

@@ design/dsfp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfp_step
// Per-string parse state and the combinational character step with field
// close and final date checks.
// ----------------------------------------------------------------------------
module dsfp_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [dsfp_pkg::ORDER_W-1:0]   cfg_wr_data,
  input  logic                           take,
  input  logic [dsfp_pkg::CHAR_W-1:0]    char_code,
  input  logic                           last,
  output logic                           res_valid,
  output dsfp_pkg::result_t              res
);

  logic [dsfp_pkg::ORDER_W-1:0]  date_order;
  logic [dsfp_pkg::DCNT_W-1:0]   digit_count, digit_count_next;
  logic [dsfp_pkg::YEAR_W-1:0]   field_value, field_value_next;
  logic [dsfp_pkg::FCNT_W-1:0]   field_count, field_count_next;
  logic [dsfp_pkg::SHORT_W-1:0]  day_store, day_store_next;
  logic [dsfp_pkg::SHORT_W-1:0]  month_store, month_store_next;
  logic [dsfp_pkg::YEAR_W-1:0]   year_store, year_store_next;
  dsfp_pkg::status_t             error_code, error_code_next;

  logic                          is_digit;
  logic                          do_close;
  logic [3:0]                    digit;
  dsfp_pkg::role_t               role;
  dsfp_pkg::status_t             final_status;

  assign is_digit = (char_code >= dsfp_pkg::CHAR_ZERO) && (char_code <= dsfp_pkg::CHAR_NINE);
  assign digit    = 4'(char_code - dsfp_pkg::CHAR_ZERO);
  assign role     = dsfp_pkg::role_of(date_order, field_count);

  always_comb begin
    digit_count_next = digit_count;
    field_value_next = field_value;
    field_count_next = field_count;
    day_store_next   = day_store;
    month_store_next = month_store;
    year_store_next  = year_store;
    error_code_next  = error_code;
    do_close         = 1'b0;
    final_status     = dsfp_pkg::STAT_OK;

    if (error_code == dsfp_pkg::STAT_OK) begin
      if (char_code == dsfp_pkg::CHAR_SLASH) begin
        do_close = 1'b1;
      end else if (is_digit) begin
        if (digit_count < dsfp_pkg::DIGITS_KEPT) begin
          field_value_next = 14'(field_value * 14'd10) + 14'(digit);
        end
        if (digit_count < dsfp_pkg::DIGITS_SAT) begin
          digit_count_next = digit_count + 3'd1;
        end
        do_close = last;
      end else begin
        error_code_next = dsfp_pkg::STAT_BAD_CHAR;
      end
    end

    if (do_close) begin
      priority if (digit_count_next == '0) begin
        error_code_next = dsfp_pkg::STAT_INCOMPLETE;
      end else if (field_count == dsfp_pkg::FIELDS_FULL) begin
        error_code_next = dsfp_pkg::STAT_EXTRA;
      end else if (role != dsfp_pkg::ROLE_YEAR && digit_count_next > dsfp_pkg::SHORT_DIGITS) begin
        error_code_next = dsfp_pkg::STAT_SHORT_LONG;
      end else if (role == dsfp_pkg::ROLE_YEAR && digit_count_next > dsfp_pkg::YEAR_DIGITS) begin
        error_code_next = dsfp_pkg::STAT_YEAR_LONG;
      end else begin
        unique case (role)
          dsfp_pkg::ROLE_DAY:   day_store_next   = field_value_next[dsfp_pkg::SHORT_W-1:0];
          dsfp_pkg::ROLE_MONTH: month_store_next = field_value_next[dsfp_pkg::SHORT_W-1:0];
          default:              year_store_next  = field_value_next;
        endcase
        field_count_next = field_count + 2'd1;
      end
      digit_count_next = '0;
      field_value_next = '0;
    end

    final_status = error_code_next;
    if (error_code_next == dsfp_pkg::STAT_OK) begin
      priority if (field_count_next != dsfp_pkg::FIELDS_FULL) begin
        final_status = dsfp_pkg::STAT_INCOMPLETE;
      end else if (month_store_next == '0 || month_store_next > dsfp_pkg::MONTHS) begin
        final_status = dsfp_pkg::STAT_BAD_MONTH;
      end else if (day_store_next > dsfp_pkg::month_len(month_store_next)) begin
        final_status = dsfp_pkg::STAT_BAD_DAY;
      end else begin
        final_status = dsfp_pkg::STAT_OK;
      end
    end

    res.status = final_status;
    if (final_status == dsfp_pkg::STAT_OK) begin
      res.day   = day_store_next;
      res.month = month_store_next;
      res.year  = year_store_next;
    end else begin
      res.day   = '0;
      res.month = '0;
      res.year  = '0;
    end
  end

  assign res_valid = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      date_order <= '0;
    end else if (cfg_wr_en) begin
      date_order <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      field_value <= '0;
      field_count <= '0;
      day_store   <= '0;
      month_store <= '0;
      year_store  <= '0;
      error_code  <= dsfp_pkg::STAT_OK;
    end else if (take) begin
      if (last) begin
        digit_count <= '0;
        field_value <= '0;
        field_count <= '0;
        day_store   <= '0;
        month_store <= '0;
        year_store  <= '0;
        error_code  <= dsfp_pkg::STAT_OK;
      end else begin
        digit_count <= digit_count_next;
        field_value <= field_value_next;
        field_count <= field_count_next;
        day_store   <= day_store_next;
        month_store <= month_store_next;
        year_store  <= year_store_next;
        error_code  <= error_code_next;
      end
    end
  end

endmodule

@@ design/dsfp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfp_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module dsfp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  dsfp_pkg::result_t    res,
  output logic                 slot_free,
  dsfp_out_if.source           out_chan
);

  logic              full;
  dsfp_pkg::result_t held;

  assign slot_free = !full || out_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_chan.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_chan.valid  = full;
  assign out_chan.day    = held.day;
  assign out_chan.month  = held.month;
  assign out_chan.year   = held.year;
  assign out_chan.status = held.status;

endmodule

@@ design/date_string_field_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_string_field_parser_top
// Slash-separated date string parser with configurable day/month/year order.
// ----------------------------------------------------------------------------
// Takes one character request per clock cycle. Each character is folded into
// the parse state in the cycle it is accepted; the request flagged last yields
// one result (day, month, year, status) in the result register, visible the
// following cycle. Input stalls only while that register holds a result the
// sink has not yet taken. The order register is written directly with no
// wait and applies at the next field close.
module date_string_field_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [dsfp_pkg::ORDER_W-1:0]   cfg_wr_data,
  dsfp_in_if.sink                        in_chan,
  dsfp_out_if.source                     out_chan
);

  logic              slot_free;
  logic              take;
  logic              res_valid;
  dsfp_pkg::result_t res;

  assign in_chan.ready = slot_free;
  assign take          = in_chan.valid && slot_free;

  dsfp_step u_step (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .char_code   (in_chan.char_code),
    .last        (in_chan.last),
    .res_valid   (res_valid),
    .res         (res)
  );

  dsfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

endmodule
